### rtl/mer_pkg.sv
// Shared types and constants for the midpoint ellipse rasteriser.
// Used by mer_ctrl, mer_dpath and midpoint_ellipse_raster; no dependencies.
package mer_pkg;

   localparam int RADIUS_BITS_DEF = 10;
   localparam int COORD_BITS_DEF  = 11;

   // request op field
   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // datapath operation codes, one per controller step
   typedef logic [3:0] dp_op_type;
   localparam dp_op_type DP_NOP   = 4'd0;
   localparam dp_op_type DP_START = 4'd1;
   localparam dp_op_type DP_STEP  = 4'd2;
   localparam dp_op_type DP_SQ_RX = 4'd3;
   localparam dp_op_type DP_SQ_RY = 4'd4;
   localparam dp_op_type DP_TERM  = 4'd5;
   localparam dp_op_type DP_INIT  = 4'd6;
   localparam dp_op_type DP_CHECK = 4'd7;
   localparam dp_op_type DP_R2A   = 4'd8;
   localparam dp_op_type DP_R2B   = 4'd9;
   localparam dp_op_type DP_R2C   = 4'd10;
   localparam dp_op_type DP_R2D   = 4'd11;
   localparam dp_op_type DP_R2E   = 4'd12;
   localparam dp_op_type DP_R2F   = 4'd13;
   localparam dp_op_type DP_EMIT  = 4'd14;

   typedef struct packed {
      dp_op_type op;
   } cmd_type;

   typedef struct packed {
      logic active;       // points remain in the current ellipse
      logic need_switch;  // region 1 test has failed, region 2 term due
   } sts_type;

endpackage

### rtl/midpoint_ellipse_raster.sv
// Top level of the two-region midpoint ellipse rasteriser.
// Instantiates mer_ctrl and mer_dpath; depends on mer_pkg.
//
//   channel   handshake              payload
//   req_      req_valid/req_ready    op, center_x, center_y, radius_x, radius_y
//   rsp_      rsp_valid/rsp_ready    pa..pd x/y, in_region_two, last
//
// A step transfer runs accept, settle test, then result load; a start first runs
// SQX, SQY and TERM on the single shared multiplier, forming rx^2, ry^2 and
// rx^2*ry one product a cycle, then INIT. A region 2 switch adds R2A to R2F for five products.
// Reset clears the sequencer and all iteration state; the block is idle after.
// A result waits in the output register; the block takes the next request
// meanwhile and only stalls at result load if that register is still full.
// A step request with no ellipse in progress is taken and gives no result.
module midpoint_ellipse_raster #(
   parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF,
   parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_op,
   input  logic [COORD_BITS-1:0]        req_center_x,
   input  logic [COORD_BITS-1:0]        req_center_y,
   input  logic [RADIUS_BITS-1:0]       req_radius_x,
   input  logic [RADIUS_BITS-1:0]       req_radius_y,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS+1:0] rsp_pa_x,
   output logic signed [COORD_BITS+1:0] rsp_pa_y,
   output logic signed [COORD_BITS+1:0] rsp_pb_x,
   output logic signed [COORD_BITS+1:0] rsp_pb_y,
   output logic signed [COORD_BITS+1:0] rsp_pc_x,
   output logic signed [COORD_BITS+1:0] rsp_pc_y,
   output logic signed [COORD_BITS+1:0] rsp_pd_x,
   output logic signed [COORD_BITS+1:0] rsp_pd_y,
   output logic                         rsp_in_region_two,
   output logic                         rsp_last
);
   import mer_pkg::*;

   cmd_type cmd;   // sequencer -> datapath op
   sts_type sts;   // datapath -> sequencer flags

   mer_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mer_dpath #(
      .RADIUS_BITS (RADIUS_BITS),
      .COORD_BITS  (COORD_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_center_x      (req_center_x),
      .req_center_y      (req_center_y),
      .req_radius_x      (req_radius_x),
      .req_radius_y      (req_radius_y),
      .rsp_pa_x          (rsp_pa_x),
      .rsp_pa_y          (rsp_pa_y),
      .rsp_pb_x          (rsp_pb_x),
      .rsp_pb_y          (rsp_pb_y),
      .rsp_pc_x          (rsp_pc_x),
      .rsp_pc_y          (rsp_pc_y),
      .rsp_pd_x          (rsp_pd_x),
      .rsp_pd_y          (rsp_pd_y),
      .rsp_in_region_two (rsp_in_region_two),
      .rsp_last          (rsp_last)
   );

   // a loaded result is presented next cycle, flagged last exactly when the
   // ellipse has just finished
   a_emit_last: assert property (@(posedge clock) disable iff (reset)
      cmd.op == DP_EMIT |=> rsp_valid && (rsp_last == !sts.active))
      else $error("result last flag disagrees with ellipse state");

   // iteration only runs on a live ellipse
   a_step_active: assert property (@(posedge clock) disable iff (reset)
      cmd.op == DP_STEP |-> sts.active)
      else $error("step issued with no ellipse in progress");

   // an ellipse only finishes when its final point is loaded
   a_end_at_emit: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(sts.active) |-> $past(cmd.op == DP_EMIT))
      else $error("ellipse ended without a final point");

endmodule

### rtl/mer_ctrl.sv
// Sequencer for the ellipse rasteriser: issues datapath ops, owns handshakes.
// Depends on mer_pkg.
module mer_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_op,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  mer_pkg::sts_type sts,
   output mer_pkg::cmd_type cmd
);
   import mer_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SQX   = 4'd1;
   localparam logic [3:0] S_SQY   = 4'd2;
   localparam logic [3:0] S_TERM  = 4'd3;
   localparam logic [3:0] S_INIT  = 4'd4;
   localparam logic [3:0] S_CHECK = 4'd5;
   localparam logic [3:0] S_R2A   = 4'd6;
   localparam logic [3:0] S_R2B   = 4'd7;
   localparam logic [3:0] S_R2C   = 4'd8;
   localparam logic [3:0] S_R2D   = 4'd9;
   localparam logic [3:0] S_R2E   = 4'd10;
   localparam logic [3:0] S_R2F   = 4'd11;
   localparam logic [3:0] S_EMIT  = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = DP_NOP;
      req_ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_op == OP_START) begin
                  cmd.op   = DP_START;
                  state_in = S_SQX;
               end else if (sts.active) begin
                  cmd.op   = DP_STEP;
                  state_in = S_CHECK;
               end
            end
         end
         S_SQX: begin
            cmd.op   = DP_SQ_RX;
            state_in = S_SQY;
         end
         S_SQY: begin
            cmd.op   = DP_SQ_RY;
            state_in = S_TERM;
         end
         S_TERM: begin
            cmd.op   = DP_TERM;
            state_in = S_INIT;
         end
         S_INIT: begin
            cmd.op   = DP_INIT;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.op   = DP_CHECK;
            state_in = sts.need_switch ? S_R2A : S_EMIT;
         end
         S_R2A: begin
            cmd.op   = DP_R2A;
            state_in = S_R2B;
         end
         S_R2B: begin
            cmd.op   = DP_R2B;
            state_in = S_R2C;
         end
         S_R2C: begin
            cmd.op   = DP_R2C;
            state_in = S_R2D;
         end
         S_R2D: begin
            cmd.op   = DP_R2D;
            state_in = S_R2E;
         end
         S_R2E: begin
            cmd.op   = DP_R2E;
            state_in = S_R2F;
         end
         S_R2F: begin
            cmd.op   = DP_R2F;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = DP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/mer_dpath.sv
// Datapath for the ellipse rasteriser: offsets, gradients, decision term,
// one shared registered multiplier and the result register. Depends on mer_pkg.
module mer_dpath #(
   parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF,
   parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  mer_pkg::cmd_type             cmd,
   output mer_pkg::sts_type             sts,
   input  logic [COORD_BITS-1:0]        req_center_x,
   input  logic [COORD_BITS-1:0]        req_center_y,
   input  logic [RADIUS_BITS-1:0]       req_radius_x,
   input  logic [RADIUS_BITS-1:0]       req_radius_y,
   output logic signed [COORD_BITS+1:0] rsp_pa_x,
   output logic signed [COORD_BITS+1:0] rsp_pa_y,
   output logic signed [COORD_BITS+1:0] rsp_pb_x,
   output logic signed [COORD_BITS+1:0] rsp_pb_y,
   output logic signed [COORD_BITS+1:0] rsp_pc_x,
   output logic signed [COORD_BITS+1:0] rsp_pc_y,
   output logic signed [COORD_BITS+1:0] rsp_pd_x,
   output logic signed [COORD_BITS+1:0] rsp_pd_y,
   output logic                         rsp_in_region_two,
   output logic                         rsp_last
);
   import mer_pkg::*;

   localparam int OFF_W  = RADIUS_BITS + 2;
   localparam int SQ_W   = 2 * RADIUS_BITS;
   localparam int GRAD_W = 3 * RADIUS_BITS + 3;
   localparam int DEC_W  = 4 * RADIUS_BITS + 4;
   localparam int MUL_W  = 2 * RADIUS_BITS + 4;
   localparam int PROD_W = 2 * MUL_W;
   localparam int OUT_W  = COORD_BITS + 2;

   logic        [COORD_BITS-1:0]  cx_ff, cy_ff;
   logic        [RADIUS_BITS-1:0] rx_ff;
   logic signed [OFF_W-1:0]       off_x_ff, off_x_in, off_y_ff, off_y_in;
   logic        [GRAD_W-1:0]      gx_ff, gx_in, gy_ff, gy_in;
   logic signed [DEC_W-1:0]       dec_ff, dec_in;
   logic        [SQ_W-1:0]        rx_sq_ff, ry_sq_ff;
   logic                          region_ff, region_in;
   logic                          active_ff, active_in;
   logic                          reg2_ff;
   logic signed [PROD_W-1:0]      prod_ff;
   logic signed [MUL_W-1:0]       tmp_ff;
   logic signed [DEC_W-1:0]       acc_ff;
   logic signed [MUL_W-1:0]       mul_a, mul_b;

   logic signed [OUT_W-1:0]       pa_x_ff, pa_y_ff, pb_x_ff, pb_y_ff;
   logic signed [OUT_W-1:0]       pc_x_ff, pc_y_ff, pd_x_ff, pd_y_ff;
   logic                          in_r2_ff, last_ff;

   // step terms
   logic        [GRAD_W-1:0]      gx_step, gy_step;
   logic                          inc_x, dec_y;
   logic signed [DEC_W-1:0]       prod_d, rx_sq_d, ry_sq_d, gx_step_d, gy_step_d;
   logic                          fin;

   // result terms
   logic signed [OUT_W-1:0]       cx_o, cy_o, ox_o, oy_o;

   assign prod_d    = DEC_W'(prod_ff);
   assign rx_sq_d   = signed'(DEC_W'(rx_sq_ff));
   assign ry_sq_d   = signed'(DEC_W'(ry_sq_ff));
   assign gx_step   = gx_ff + GRAD_W'({ry_sq_ff, 1'b0});
   assign gy_step   = gy_ff - GRAD_W'({rx_sq_ff, 1'b0});
   assign gx_step_d = signed'(DEC_W'(gx_step));
   assign gy_step_d = signed'(DEC_W'(gy_step));
   assign inc_x     = !region_ff || !(dec_ff > 0);
   assign dec_y     = region_ff || !dec_ff[DEC_W-1];

   assign sts.active      = active_ff;
   assign sts.need_switch = !region_ff && !(gx_ff < gy_ff);
   assign fin             = region_ff && (off_y_ff[OFF_W-1] || off_y_ff == '0);

   // shared multiplier operands
   always_comb begin
      case (cmd.op)
         DP_SQ_RX: begin
            mul_a = signed'(MUL_W'(rx_ff));
            mul_b = signed'(MUL_W'(rx_ff));
         end
         DP_SQ_RY: begin
            mul_a = MUL_W'(off_y_ff);
            mul_b = MUL_W'(off_y_ff);
         end
         DP_TERM: begin
            mul_a = signed'(MUL_W'(rx_sq_ff));
            mul_b = MUL_W'(off_y_ff);
         end
         DP_R2A: begin
            mul_a = MUL_W'(off_x_ff);
            mul_b = MUL_W'(off_x_ff);
         end
         DP_R2B: begin
            mul_a = MUL_W'(off_y_ff) - MUL_W'(1);
            mul_b = MUL_W'(off_y_ff) - MUL_W'(1);
         end
         DP_R2C: begin
            mul_a = signed'(MUL_W'(ry_sq_ff));
            mul_b = tmp_ff;
         end
         DP_R2D: begin
            mul_a = signed'(MUL_W'(rx_sq_ff));
            mul_b = tmp_ff;
         end
         DP_R2E: begin
            mul_a = signed'(MUL_W'(rx_sq_ff));
            mul_b = signed'(MUL_W'(ry_sq_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // state update
   always_comb begin
      off_x_in  = off_x_ff;
      off_y_in  = off_y_ff;
      gx_in     = gx_ff;
      gy_in     = gy_ff;
      dec_in    = dec_ff;
      region_in = region_ff;
      active_in = active_ff;
      case (cmd.op)
         DP_START: begin
            off_x_in  = '0;
            off_y_in  = signed'(OFF_W'(req_radius_y));
            gx_in     = '0;
            region_in = 1'b0;
            active_in = 1'b1;
         end
         DP_STEP: begin
            if (inc_x) begin
               off_x_in = off_x_ff + OFF_W'(1);
               gx_in    = gx_step;
            end
            if (dec_y) begin
               off_y_in = off_y_ff - OFF_W'(1);
               gy_in    = gy_step;
            end
            dec_in = dec_ff + (region_ff ? rx_sq_d : ry_sq_d)
                   + (inc_x ? gx_step_d : '0) - (dec_y ? gy_step_d : '0);
         end
         DP_INIT: begin
            gy_in  = GRAD_W'(prod_ff) << 1;
            dec_in = ry_sq_d - prod_d + signed'(DEC_W'(rx_sq_ff >> 2));
         end
         DP_CHECK: begin
            if (sts.need_switch) begin
               region_in = 1'b1;
            end
         end
         DP_R2F: begin
            dec_in = acc_ff - prod_d;
         end
         DP_EMIT: begin
            active_in = !fin;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_x_ff  <= '0;
         off_y_ff  <= '0;
         gx_ff     <= '0;
         gy_ff     <= '0;
         dec_ff    <= '0;
         region_ff <= 1'b0;
         active_ff <= 1'b0;
      end else begin
         off_x_ff  <= off_x_in;
         off_y_ff  <= off_y_in;
         gx_ff     <= gx_in;
         gy_ff     <= gy_in;
         dec_ff    <= dec_in;
         region_ff <= region_in;
         active_ff <= active_in;
      end
   end

   // payload and scratch registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (cmd.op)
         DP_START: begin
            cx_ff   <= req_center_x;
            cy_ff   <= req_center_y;
            rx_ff   <= req_radius_x;
            reg2_ff <= 1'b0;
         end
         DP_STEP:  reg2_ff  <= region_ff;
         DP_SQ_RY: rx_sq_ff <= SQ_W'(prod_ff);
         DP_TERM:  ry_sq_ff <= SQ_W'(prod_ff);
         DP_R2B:   tmp_ff   <= MUL_W'(prod_ff) + MUL_W'(off_x_ff);
         DP_R2C:   tmp_ff   <= MUL_W'(prod_ff);
         DP_R2D:   acc_ff   <= prod_d + signed'(DEC_W'(ry_sq_ff >> 2));
         DP_R2E:   acc_ff   <= acc_ff + prod_d;
         default: begin
         end
      endcase
   end

   assign cx_o = signed'(OUT_W'(cx_ff));
   assign cy_o = signed'(OUT_W'(cy_ff));
   assign ox_o = OUT_W'(off_x_ff);
   assign oy_o = OUT_W'(off_y_ff);

   always_ff @(posedge clock) begin
      if (cmd.op == DP_EMIT) begin
         pa_x_ff  <= cx_o + ox_o;
         pa_y_ff  <= cy_o + oy_o;
         pb_x_ff  <= cx_o - ox_o;
         pb_y_ff  <= cy_o + oy_o;
         pc_x_ff  <= cx_o + ox_o;
         pc_y_ff  <= cy_o - oy_o;
         pd_x_ff  <= cx_o - ox_o;
         pd_y_ff  <= cy_o - oy_o;
         in_r2_ff <= reg2_ff;
         last_ff  <= fin;
      end
   end

   assign rsp_pa_x          = pa_x_ff;
   assign rsp_pa_y          = pa_y_ff;
   assign rsp_pb_x          = pb_x_ff;
   assign rsp_pb_y          = pb_y_ff;
   assign rsp_pc_x          = pc_x_ff;
   assign rsp_pc_y          = pc_y_ff;
   assign rsp_pd_x          = pd_x_ff;
   assign rsp_pd_y          = pd_y_ff;
   assign rsp_in_region_two = in_r2_ff;
   assign rsp_last          = last_ff;

endmodule
